>>> hdl/pedd_pkg.sv
// shared constants, payload types and sequencer states of the palette dither unit
package pedd_pkg;

  // storage sizes
  localparam int unsigned MAX_WIDTH    = 1024;
  localparam int unsigned COL_AW       = $clog2(MAX_WIDTH);
  localparam int unsigned COL_W        = COL_AW + 1;
  localparam int unsigned PALETTE_SIZE = 32;
  localparam int unsigned PAL_AW       = $clog2(PALETTE_SIZE);
  localparam int unsigned ENT_W        = PAL_AW + 1;

  // pixel and error widths
  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned ERR_W     = 13;
  localparam int unsigned ERR_VEC_W = NUM_CH * ERR_W;
  localparam int unsigned COLOR_W   = NUM_CH * CH_W;
  localparam int unsigned DIST_W    = 2 * CH_W + 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST   = CFG_DATA_W'(640);
  localparam logic [ENT_W-1:0]      ENTRIES_RST = ENT_W'(PALETTE_SIZE);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH     = 1'b0,
    CFG_PALETTE_ENTRIES = 1'b1
  } cfg_reg_e;

  // item kinds
  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PIXEL   = 1'b1;

  // channel order inside packed color and error vectors
  localparam int unsigned CH_RED   = 2;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 0;

  typedef struct packed {
    logic              mode;
    logic [PAL_AW-1:0] entry_index;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic              frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PAL_AW-1:0] chosen_index;
    logic [CH_W-1:0]   out_red;
    logic [CH_W-1:0]   out_green;
    logic [CH_W-1:0]   out_blue;
  } out_item_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0]  color_t;
  typedef logic [NUM_CH-1:0][ERR_W-1:0] err_vec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_ADD,
    ST_SEARCH,
    ST_SPREAD,
    ST_POST,
    ST_END_A,
    ST_END_B,
    ST_OUT
  } pedd_state_e;

endpackage

>>> hdl/palette_error_diffusion_dither_unit.sv
// top level of the palette error-diffusion dither unit
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries either a palette
// load (mode 0, written in the accept cycle) or one RGB pixel in raster order.
// Each pixel gives one transaction on the output channel (out_valid_o /
// out_stall_i / out_data_o): the nearest palette index and its color.
// Configuration (cfg_we_i / cfg_index_i / cfg_wdata_i) sets the image width and
// the number of palette entries searched; write it only while the unit is idle.
// A pixel passes the check, read, add, search, spread, post and output states
// from accept to the next accept; one shared distance/compare unit visits one
// palette entry per cycle in the search. A pixel that closes a row adds the
// line buffer flush states END_A and END_B, as does a narrowed width that
// closed the row before it. Palette loads are accepted one per cycle while idle.
// The finished result sits in an output register, so a stalled receiver only
// holds the unit once the next pixel is done. Diffused error for the next row
// lives in a single line buffer ram with a fill count, so reset and frame start
// clear it at once with no sweep. Reset sets width 640 and 32 entries; the
// palette ram is not cleared and must be loaded before pixels are sent.
module palette_error_diffusion_dither_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pedd_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pedd_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [pedd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pedd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned SUM_W = pedd_pkg::ERR_W + 2;
  localparam int unsigned CH_W  = pedd_pkg::CH_W;
  localparam int unsigned ERR_W = pedd_pkg::ERR_W;

  // sequencer and control state
  pedd_pkg::pedd_state_e state_q, state_d;
  logic [pedd_pkg::CFG_DATA_W-1:0] width_q;
  logic [pedd_pkg::ENT_W-1:0]      entries_q;
  logic [pedd_pkg::COL_W-1:0]      col_q;
  logic [pedd_pkg::COL_W-1:0]      fill_q;
  pedd_pkg::err_vec_t              acc_a_q;
  pedd_pkg::err_vec_t              acc_b_q;
  pedd_pkg::err_vec_t              right_q;
  logic                            b_set_q;
  logic                            pre_q;
  logic                            out_valid_q;

  // payload registers
  pedd_pkg::color_t           pix_q;
  pedd_pkg::color_t           v_q;
  logic                       rd_ok_q;
  logic [pedd_pkg::PAL_AW-1:0] idx_q;
  logic [pedd_pkg::PAL_AW-1:0] best_idx_q;
  pedd_pkg::color_t           best_col_q;
  logic [pedd_pkg::DIST_W-1:0] best_d_q;
  pedd_pkg::out_item_t        out_q;

  // memory ports
  logic                        pal_we;
  pedd_pkg::color_t            pal_wdata;
  logic [pedd_pkg::PAL_AW-1:0] pal_raddr;
  pedd_pkg::color_t            pal_rdata;
  logic                        buf_we;
  logic [pedd_pkg::COL_AW-1:0] buf_waddr;
  pedd_pkg::err_vec_t          buf_wdata;
  logic [pedd_pkg::COL_AW-1:0] buf_raddr;
  pedd_pkg::err_vec_t          buf_rdata;

  // datapath nets
  logic [pedd_pkg::COL_W-1:0]  eff_w;
  logic [pedd_pkg::PAL_AW-1:0] last_idx;
  logic                        row_full;
  logic                        more_cols;
  pedd_pkg::color_t            v_d;
  logic [pedd_pkg::DIST_W-1:0] cand_dist;
  logic                        take;
  pedd_pkg::err_vec_t          left_wdata;
  pedd_pkg::err_vec_t          acc_a_d;
  pedd_pkg::err_vec_t          err1_vec;
  pedd_pkg::err_vec_t          err7_vec;

  // palette store
  pedd_ram #(
    .WIDTH(pedd_pkg::COLOR_W),
    .DEPTH(pedd_pkg::PALETTE_SIZE)
  ) u_pal_ram (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(in_data_i.entry_index),
    .wdata_i(pal_wdata),
    .raddr_i(pal_raddr),
    .rdata_o(pal_rdata)
  );

  // line buffer of diffused error, one row deep
  pedd_ram #(
    .WIDTH(pedd_pkg::ERR_VEC_W),
    .DEPTH(pedd_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (buf_we),
    .waddr_i(buf_waddr),
    .wdata_i(buf_wdata),
    .raddr_i(buf_raddr),
    .rdata_o(buf_rdata)
  );

  assign pal_wdata = {in_data_i.red, in_data_i.green, in_data_i.blue};

  // effective width and last searched entry
  always_comb begin
    if (width_q == '0) begin
      eff_w = pedd_pkg::COL_W'(1);
    end else if (width_q > pedd_pkg::CFG_DATA_W'(pedd_pkg::MAX_WIDTH)) begin
      eff_w = pedd_pkg::COL_W'(pedd_pkg::MAX_WIDTH);
    end else begin
      eff_w = pedd_pkg::COL_W'(width_q);
    end
    if (entries_q == '0) begin
      last_idx = '0;
    end else if (entries_q > pedd_pkg::ENT_W'(pedd_pkg::PALETTE_SIZE)) begin
      last_idx = pedd_pkg::PAL_AW'(pedd_pkg::PALETTE_SIZE - 1);
    end else begin
      last_idx = pedd_pkg::PAL_AW'(entries_q - 1'b1);
    end
  end

  assign row_full  = (col_q >= eff_w);
  assign more_cols = (({1'b0, col_q} + 1'b1) < {1'b0, eff_w});

  // pixel plus diffused error, floored and clamped
  always_comb begin
    logic signed [ERR_W-1:0] buf_e;
    logic signed [ERR_W-1:0] right_e;
    logic signed [SUM_W-1:0] sum;
    for (int c = 0; c < pedd_pkg::NUM_CH; c++) begin
      buf_e   = rd_ok_q ? $signed(buf_rdata[c]) : '0;
      right_e = $signed(right_q[c]);
      sum     = $signed(SUM_W'({pix_q[c], 4'b0000})) + SUM_W'(buf_e) + SUM_W'(right_e);
      if (sum[SUM_W-1]) begin
        v_d[c] = '0;
      end else if (|sum[SUM_W-2:CH_W+4]) begin
        v_d[c] = '1;
      end else begin
        v_d[c] = sum[CH_W+3:4];
      end
    end
  end

  // shared distance and compare unit
  always_comb begin
    logic signed [CH_W:0]     dr;
    logic signed [2*CH_W+1:0] sq;
    cand_dist = '0;
    for (int c = 0; c < pedd_pkg::NUM_CH; c++) begin
      dr        = $signed({1'b0, v_q[c]}) - $signed({1'b0, pal_rdata[c]});
      sq        = dr * dr;
      cand_dist = cand_dist + pedd_pkg::DIST_W'(sq[2*CH_W:0]);
    end
  end

  assign take = (idx_q == '0) || (cand_dist < best_d_q);

  // quantization error and its weighted shares
  always_comb begin
    logic signed [CH_W:0]  e;
    logic signed [ERR_W-1:0] e1;
    logic signed [ERR_W-1:0] e3;
    logic signed [ERR_W-1:0] e5;
    for (int c = 0; c < pedd_pkg::NUM_CH; c++) begin
      e  = $signed({1'b0, v_q[c]}) - $signed({1'b0, best_col_q[c]});
      e1 = ERR_W'(e);
      e3 = (e1 <<< 1) + e1;
      e5 = (e1 <<< 2) + e1;
      left_wdata[c] = $signed(acc_a_q[c]) + e3;
      acc_a_d[c]    = $signed(acc_b_q[c]) + e5;
      err1_vec[c]   = e1;
      err7_vec[c]   = (e1 <<< 3) - e1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pedd_pkg::ST_IDLE: begin
        if (in_valid_i && (in_data_i.mode == pedd_pkg::MODE_PIXEL)) begin
          state_d = pedd_pkg::ST_CHECK;
        end
      end
      pedd_pkg::ST_CHECK: begin
        state_d = row_full ? pedd_pkg::ST_END_A : pedd_pkg::ST_READ;
      end
      pedd_pkg::ST_READ:   state_d = pedd_pkg::ST_ADD;
      pedd_pkg::ST_ADD:    state_d = pedd_pkg::ST_SEARCH;
      pedd_pkg::ST_SEARCH: begin
        if (idx_q == last_idx) begin
          state_d = pedd_pkg::ST_SPREAD;
        end
      end
      pedd_pkg::ST_SPREAD: state_d = pedd_pkg::ST_POST;
      pedd_pkg::ST_POST: begin
        state_d = row_full ? pedd_pkg::ST_END_A : pedd_pkg::ST_OUT;
      end
      pedd_pkg::ST_END_A:  state_d = pedd_pkg::ST_END_B;
      pedd_pkg::ST_END_B: begin
        state_d = pre_q ? pedd_pkg::ST_READ : pedd_pkg::ST_OUT;
      end
      pedd_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = pedd_pkg::ST_IDLE;
        end
      end
      default: state_d = pedd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: memory controls and input stall
  always_comb begin
    in_stall_o = 1'b1;
    pal_we     = 1'b0;
    pal_raddr  = '0;
    buf_we     = 1'b0;
    buf_waddr  = pedd_pkg::COL_AW'(col_q - 1'b1);
    buf_wdata  = left_wdata;
    buf_raddr  = col_q[pedd_pkg::COL_AW-1:0];
    case (state_q)
      pedd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        pal_we     = in_valid_i && (in_data_i.mode == pedd_pkg::MODE_PALETTE);
      end
      pedd_pkg::ST_SEARCH: begin
        pal_raddr = pedd_pkg::PAL_AW'(idx_q + 1'b1);
      end
      pedd_pkg::ST_SPREAD: begin
        buf_we = (col_q != '0);
      end
      pedd_pkg::ST_END_A: begin
        buf_we    = 1'b1;
        buf_wdata = acc_a_q;
      end
      pedd_pkg::ST_END_B: begin
        buf_we    = b_set_q;
        buf_waddr = col_q[pedd_pkg::COL_AW-1:0];
        buf_wdata = acc_b_q;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pedd_pkg::ST_IDLE;
      width_q     <= pedd_pkg::WIDTH_RST;
      entries_q   <= pedd_pkg::ENTRIES_RST;
      col_q       <= '0;
      fill_q      <= '0;
      acc_a_q     <= '0;
      acc_b_q     <= '0;
      right_q     <= '0;
      b_set_q     <= 1'b0;
      pre_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // configuration writes
      if (cfg_we_i) begin
        case (pedd_pkg::cfg_reg_e'(cfg_index_i))
          pedd_pkg::CFG_IMAGE_WIDTH:     width_q   <= cfg_wdata_i;
          pedd_pkg::CFG_PALETTE_ENTRIES: entries_q <= cfg_wdata_i[pedd_pkg::ENT_W-1:0];
          default: begin
          end
        endcase
      end
      // position and error bookkeeping
      case (state_q)
        pedd_pkg::ST_IDLE: begin
          if (in_valid_i && (in_data_i.mode == pedd_pkg::MODE_PIXEL) &&
              in_data_i.frame_start) begin
            col_q   <= '0;
            fill_q  <= '0;
            acc_a_q <= '0;
            acc_b_q <= '0;
            right_q <= '0;
            b_set_q <= 1'b0;
          end
        end
        pedd_pkg::ST_CHECK: pre_q <= 1'b1;
        pedd_pkg::ST_SPREAD: begin
          acc_a_q <= acc_a_d;
          acc_b_q <= more_cols ? err1_vec : '0;
          right_q <= more_cols ? err7_vec : '0;
          b_set_q <= more_cols;
          col_q   <= col_q + 1'b1;
        end
        pedd_pkg::ST_POST: pre_q <= 1'b0;
        pedd_pkg::ST_END_B: begin
          fill_q  <= col_q + pedd_pkg::COL_W'(b_set_q);
          col_q   <= '0;
          acc_a_q <= '0;
          acc_b_q <= '0;
          right_q <= '0;
          b_set_q <= 1'b0;
        end
        default: begin
        end
      endcase
      // output register
      if ((state_q == pedd_pkg::ST_OUT) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      pedd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          pix_q <= {in_data_i.red, in_data_i.green, in_data_i.blue};
        end
      end
      pedd_pkg::ST_READ: rd_ok_q <= (col_q < fill_q);
      pedd_pkg::ST_ADD: begin
        v_q   <= v_d;
        idx_q <= '0;
      end
      pedd_pkg::ST_SEARCH: begin
        if (take) begin
          best_d_q   <= cand_dist;
          best_idx_q <= idx_q;
          best_col_q <= pal_rdata;
        end
        idx_q <= idx_q + 1'b1;
      end
      pedd_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_q.chosen_index <= best_idx_q;
          out_q.out_red      <= best_col_q[pedd_pkg::CH_RED];
          out_q.out_green    <= best_col_q[pedd_pkg::CH_GREEN];
          out_q.out_blue     <= best_col_q[pedd_pkg::CH_BLUE];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/pedd_ram.sv
// generic simple dual-port ram with registered read
module pedd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/pedd_checker.sv
// port-level assertions for the palette dither unit, bound to the top level
module pedd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pedd_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pedd_pkg::out_item_t out_data_o
);

  // a stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result transaction keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // an accepted pixel occupies the unit on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.mode == pedd_pkg::MODE_PIXEL) |=> in_stall_o)
    else $error("pixel accepted without busy period");

  // a palette load never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.mode == pedd_pkg::MODE_PALETTE) &&
    !out_valid_o |=> !out_valid_o)
    else $error("result raised by palette load");

  // a new result only appears after the unit was busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while idle");

endmodule

bind palette_error_diffusion_dither_unit pedd_checker u_pedd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

>>> test/tb_palette_error_diffusion_dither_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the palette error-diffusion dither unit
module tb_palette_error_diffusion_dither_unit;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  pedd_pkg::in_item_t              in_data_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  pedd_pkg::out_item_t             out_data_o;
  logic                            cfg_we_i    = 1'b0;
  pedd_pkg::cfg_reg_e              cfg_index_i = pedd_pkg::CFG_IMAGE_WIDTH;
  logic [pedd_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  palette_error_diffusion_dither_unit dut (.*);

  // predictor state: registers, palette, two rows of diffused error, column
  logic [pedd_pkg::CFG_DATA_W-1:0] width_reg;
  logic [pedd_pkg::ENT_W-1:0]      entries_reg;
  logic [pedd_pkg::COLOR_W-1:0]    pal_mem [pedd_pkg::PALETTE_SIZE];
  int                    cur_err [pedd_pkg::MAX_WIDTH][pedd_pkg::NUM_CH];
  int                    nxt_err [pedd_pkg::MAX_WIDTH][pedd_pkg::NUM_CH];
  int unsigned           col_pos;
  pedd_pkg::out_item_t   expected_px [$];

  // run bookkeeping
  bit          idling_on   = 1'b1;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  int unsigned n_pixels    = 0;
  int unsigned n_frames    = 0;
  int unsigned n_loads     = 0;
  int unsigned n_writes    = 0;
  int unsigned n_checked   = 0;
  pedd_pkg::out_item_t want;

  always #6 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_px.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk_i) begin
    if (!idling_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", n_checked, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [pedd_pkg::CH_W-1:0] got,
                             input logic [pedd_pkg::CH_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  // compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_px.size() == 0) begin
        report_mismatch($sformatf("index %0d arrived with nothing pending",
                                  out_data_o.chosen_index));
      end else begin
        want = expected_px.pop_front();
        check_field("chosen_index", pedd_pkg::CH_W'(out_data_o.chosen_index),
                    pedd_pkg::CH_W'(want.chosen_index));
        check_field("out_red", out_data_o.out_red, want.out_red);
        check_field("out_green", out_data_o.out_green, want.out_green);
        check_field("out_blue", out_data_o.out_blue, want.out_blue);
      end
      n_checked++;
    end
  end

  function automatic void clear_errors();
    for (int x = 0; x < pedd_pkg::MAX_WIDTH; x++)
      for (int c = 0; c < pedd_pkg::NUM_CH; c++) begin
        cur_err[x][c] = 0;
        nxt_err[x][c] = 0;
      end
  endfunction

  // row below becomes the current row
  function automatic void next_row();
    for (int x = 0; x < pedd_pkg::MAX_WIDTH; x++)
      for (int c = 0; c < pedd_pkg::NUM_CH; c++) begin
        cur_err[x][c] = nxt_err[x][c];
        nxt_err[x][c] = 0;
      end
    col_pos = 0;
  endfunction

  // one pixel: add held error, pick nearest color, spread the difference
  function automatic pedd_pkg::out_item_t dither_pixel(input pedd_pkg::in_item_t px);
    int unsigned               w, n, x, best;
    int                        best_d, d, sum, diff;
    int                        lvl [pedd_pkg::NUM_CH];
    int                        pc [pedd_pkg::NUM_CH];
    int                        err [pedd_pkg::NUM_CH];
    logic [pedd_pkg::CH_W-1:0] chan [pedd_pkg::NUM_CH];
    pedd_pkg::out_item_t       res;
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    if (px.frame_start) begin
      clear_errors();
      col_pos = 0;
    end
    w = (width_reg == 0) ? 1 :
        (width_reg > pedd_pkg::MAX_WIDTH) ? pedd_pkg::MAX_WIDTH : width_reg;
    n = (entries_reg == 0) ? 1 :
        (entries_reg > pedd_pkg::PALETTE_SIZE) ? pedd_pkg::PALETTE_SIZE : entries_reg;
    if (col_pos >= w) next_row();
    x = col_pos;
    // floor to whole units and clamp to the channel range
    for (int c = 0; c < pedd_pkg::NUM_CH; c++) begin
      sum = int'(chan[c]) * 16 + cur_err[x][c];
      lvl[c] = (sum < 0) ? 0 : (sum / 16 > 255) ? 255 : sum / 16;
    end
    // least squared distance, lowest index keeps a tie
    best = 0;
    best_d = 32'h7fffffff;
    for (int unsigned i = 0; i < n; i++) begin
      d = 0;
      for (int c = 0; c < pedd_pkg::NUM_CH; c++) begin
        diff = lvl[c] -
               int'(pal_mem[i][(pedd_pkg::NUM_CH-1-c)*pedd_pkg::CH_W +: pedd_pkg::CH_W]);
        d += diff * diff;
      end
      if (d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    for (int c = 0; c < pedd_pkg::NUM_CH; c++) begin
      pc[c] = int'(pal_mem[best][(pedd_pkg::NUM_CH-1-c)*pedd_pkg::CH_W +: pedd_pkg::CH_W]);
      err[c] = lvl[c] - pc[c];
      if (x + 1 < w) begin
        cur_err[x+1][c] += 7 * err[c];
        nxt_err[x+1][c] += err[c];
      end
      nxt_err[x][c] += 5 * err[c];
      if (x > 0) nxt_err[x-1][c] += 3 * err[c];
    end
    col_pos = x + 1;
    if (col_pos >= w) next_row();
    res.chosen_index = pedd_pkg::PAL_AW'(best);
    res.out_red      = pedd_pkg::CH_W'(pc[0]);
    res.out_green    = pedd_pkg::CH_W'(pc[1]);
    res.out_blue     = pedd_pkg::CH_W'(pc[2]);
    return res;
  endfunction

  // drive one transaction, starting and ending on a falling edge
  task automatic send_item(input pedd_pkg::in_item_t item);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (item.mode == pedd_pkg::MODE_PIXEL) begin
      expected_px.push_back(dither_pixel(item));
      n_pixels++;
      if (item.frame_start) n_frames++;
    end else begin
      pal_mem[item.entry_index] = {item.red, item.green, item.blue};
      n_loads++;
    end
    @(negedge clk_i);
  endtask

  // hold the sender until every pending result is out and the unit settles
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_px.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input pedd_pkg::cfg_reg_e idx,
                           input logic [pedd_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == pedd_pkg::CFG_IMAGE_WIDTH) width_reg = val;
    else entries_reg = val[pedd_pkg::ENT_W-1:0];
    n_writes++;
  endtask

  task automatic set_geometry(input logic [pedd_pkg::CFG_DATA_W-1:0] w,
                              input logic [pedd_pkg::CFG_DATA_W-1:0] n);
    write_reg(pedd_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(pedd_pkg::CFG_PALETTE_ENTRIES, n);
  endtask

  function automatic pedd_pkg::in_item_t make_pixel(input logic [pedd_pkg::COLOR_W-1:0] rgb,
                                                    input bit fs);
    pedd_pkg::in_item_t it;
    it.mode        = pedd_pkg::MODE_PIXEL;
    it.entry_index = pedd_pkg::PAL_AW'($urandom);
    {it.red, it.green, it.blue} = rgb;
    it.frame_start = fs;
    return it;
  endfunction

  function automatic pedd_pkg::in_item_t make_load(input logic [pedd_pkg::PAL_AW-1:0] idx,
                                                   input logic [pedd_pkg::COLOR_W-1:0] rgb,
                                                   input bit fs);
    pedd_pkg::in_item_t it;
    it.mode        = pedd_pkg::MODE_PALETTE;
    it.entry_index = idx;
    {it.red, it.green, it.blue} = rgb;
    it.frame_start = fs;
    return it;
  endfunction

  // channel level: saturated, close to a palette color, or anywhere
  function automatic logic [pedd_pkg::CH_W-1:0] pick_level(
      input logic [pedd_pkg::CH_W-1:0] near);
    int v;
    case ($urandom_range(0, 3))
      0: begin
        return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      end
      1: begin
        v = int'(near) + int'($urandom_range(0, 16)) - 8;
        return pedd_pkg::CH_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
      end
      default: begin
        return pedd_pkg::CH_W'($urandom);
      end
    endcase
  endfunction

  function automatic pedd_pkg::in_item_t random_pixel(input bit fs);
    logic [pedd_pkg::COLOR_W-1:0] near;
    near = pal_mem[$urandom_range(0, pedd_pkg::PALETTE_SIZE - 1)];
    return make_pixel({pick_level(near[23:16]), pick_level(near[15:8]),
                       pick_level(near[7:0])}, fs);
  endfunction

  // full palette load, then a few pixels at the reset geometry
  task automatic test_reset_defaults();
    for (int i = 0; i < pedd_pkg::PALETTE_SIZE; i++) begin
      case (i)
        0:       send_item(make_load(pedd_pkg::PAL_AW'(i), 24'h000000, 1'b0));
        1, 2:    send_item(make_load(pedd_pkg::PAL_AW'(i), 24'h020000, 1'b1));
        30:      send_item(make_load(pedd_pkg::PAL_AW'(i), 24'hff00ff, 1'b0));
        31:      send_item(make_load(pedd_pkg::PAL_AW'(i), 24'hffffff, 1'b1));
        default: send_item(make_load(pedd_pkg::PAL_AW'(i),
                                     {8'($urandom_range(16, 255)), 16'($urandom)}, 1'b0));
      endcase
    end
    send_item(make_pixel(24'h808080, 1'b1));
    send_item(make_pixel(24'h10f0a0, 1'b0));
    send_item(make_pixel(24'hfefefe, 1'b0));
    wait_for_results();
  endtask

  // distance ties, saturated colors, errors pushing past both clamps
  task automatic test_pixel_extremes();
    send_item(make_pixel(24'h010000, 1'b1));
    send_item(make_pixel(24'h020000, 1'b1));
    send_item(make_pixel(24'hffffff, 1'b1));
    send_item(make_pixel(24'h000000, 1'b1));
    send_item(make_pixel(24'hff00ff, 1'b0));
    send_item(make_pixel(24'h00ff00, 1'b0));
    send_item(make_pixel(24'h7f7f7f, 1'b0));
    send_item(make_pixel(24'hff0000, 1'b0));
    wait_for_results();
  endtask

  // zero and oversized register values, and the exact bounds
  task automatic test_register_extremes();
    logic [pedd_pkg::CFG_DATA_W-1:0] widths [5] = '{11'd0, 11'd2047, 11'd1024, 11'd1, 11'd2};
    logic [pedd_pkg::CFG_DATA_W-1:0] counts [5] = '{11'd0, 11'd63, 11'd1, 11'd32, 11'h7c2};
    for (int k = 0; k < 5; k++) begin
      set_geometry(widths[k], counts[k]);
      send_item(make_pixel(24'hffffff, 1'b1));
      send_item(make_pixel(24'h00ff80, 1'b0));
      send_item(make_pixel(24'h000000, 1'b0));
      wait_for_results();
    end
  endtask

  // narrow the row while the column sits past the new width
  task automatic test_width_shrink();
    set_geometry(11'd6, 11'd8);
    send_item(make_pixel(24'h406080, 1'b1));
    send_item(make_pixel(24'hc0a020, 1'b0));
    // frame start on a palette load must not clear the row state
    send_item(make_load(5'd20, 24'h3080c0, 1'b1));
    send_item(make_pixel(24'h9090ff, 1'b0));
    send_item(make_pixel(24'h102030, 1'b0));
    send_item(make_pixel(24'hf0e0d0, 1'b0));
    wait_for_results();
    write_reg(pedd_pkg::CFG_IMAGE_WIDTH, 11'd3);
    send_item(make_pixel(24'h55aa55, 1'b0));
    send_item(make_pixel(24'haa55aa, 1'b0));
    send_item(make_pixel(24'h202020, 1'b0));
    wait_for_results();
  endtask

  // random images in phases, each with its own geometry
  task automatic test_random_frames(input int unsigned phases, input int unsigned per_phase);
    logic [pedd_pkg::CFG_DATA_W-1:0] w;
    logic [pedd_pkg::CFG_DATA_W-1:0] n;
    for (int unsigned ph = 0; ph < phases; ph++) begin
      case ($urandom_range(0, 9))
        0:       w = pedd_pkg::CFG_DATA_W'($urandom_range(1000, 2047));
        1:       w = pedd_pkg::CFG_DATA_W'($urandom_range(13, 64));
        default: w = pedd_pkg::CFG_DATA_W'($urandom_range(1, 12));
      endcase
      if ($urandom_range(0, 3) == 0) n = pedd_pkg::CFG_DATA_W'($urandom);
      else n = pedd_pkg::CFG_DATA_W'($urandom_range(1, pedd_pkg::PALETTE_SIZE));
      set_geometry(w, n);
      for (int unsigned i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(make_load(pedd_pkg::PAL_AW'($urandom), pedd_pkg::COLOR_W'($urandom),
                              bit'($urandom_range(0, 1))));
        else
          send_item(random_pixel((i == 0 && $urandom_range(0, 1) != 0) ||
                                 $urandom_range(0, 39) == 0));
      end
      wait_for_results();
    end
  endtask

  // closing stretch with both sides running flat out
  task automatic test_quiet_finish();
    idling_on = 1'b0;
    test_random_frames(2, 45);
  endtask

  initial begin
    width_reg   = pedd_pkg::WIDTH_RST;
    entries_reg = pedd_pkg::ENTRIES_RST;
    clear_errors();
    col_pos = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_pixel_extremes();
    test_register_extremes();
    test_width_shrink();
    test_random_frames(14, 40);
    test_quiet_finish();

    $display("covered %0d pixels in %0d frame starts, %0d palette loads, %0d register writes",
             n_pixels, n_frames, n_loads, n_writes);
    $display("%0d results checked, %0d mismatches", n_checked, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
